// File: src/decimating_peak_level_meter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimating peak level meter.
// Clocked, reset-qualified property checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef DECIMATING_PEAK_LEVEL_METER_MACROS_SVH
`define DECIMATING_PEAK_LEVEL_METER_MACROS_SVH

// Same-cycle implication: when pre holds, post holds on the same edge.
`define DPLM_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication: when pre holds, post holds on the following edge.
`define DPLM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: src/dplm_pkg.sv
// ----------------------------------------------------------------------------
// dplm_pkg
// Types and constants shared by the decimating peak level meter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dplm_pkg;

    // Field widths.
    localparam int SAMPLE_W    = 16;
    localparam int BYTE_W      = 8;
    localparam int FACTOR_W    = 4;
    localparam int PHASE_W     = 3;
    localparam int LENGTH_W    = 12;
    localparam int THRESH_W    = 8;
    localparam int LEVEL_W     = 2;
    localparam int FRAME_NUM_W = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int OUT_DATA_W  = 64;

    // Limits of the configuration values.
    localparam logic [FACTOR_W-1:0] MAX_FACTOR       = 4'd8;
    localparam logic [FACTOR_W-1:0] MIN_FACTOR       = 4'd1;
    localparam logic [LENGTH_W-1:0] MIN_FRAME_LENGTH = 12'd1;
    localparam logic [BYTE_W-1:0]   MAX_MAGNITUDE    = 8'd128;

    // Reset values of the configuration registers.
    localparam logic [FACTOR_W-1:0] RST_FACTOR   = 4'd4;
    localparam logic [LENGTH_W-1:0] RST_LENGTH   = 12'd1000;
    localparam logic [THRESH_W-1:0] RST_LOW_THR  = 8'd4;
    localparam logic [THRESH_W-1:0] RST_HIGH_THR = 8'd16;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DECIMATION   = 2'd0,
        CFG_FRAME_LENGTH = 2'd1,
        CFG_LOW_THR      = 2'd2,
        CFG_HIGH_THR     = 2'd3
    } t_cfg_index;

    // Noise level classes.
    localparam logic [LEVEL_W-1:0] LEVEL_QUIET    = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MODERATE = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_LOUD     = 2'd2;

    // Configuration as seen by the frame statistics unit.
    typedef struct packed {
        logic [FACTOR_W-1:0] decimation_factor;
        logic [LENGTH_W-1:0] frame_length;
        logic [THRESH_W-1:0] low_thr;
        logic [THRESH_W-1:0] high_thr;
    } t_cfg;

    // One result word, plus a flag that says the input sample was kept.
    typedef struct packed {
        logic                     keep;
        logic signed [BYTE_W-1:0] sample_byte;
        logic                     frame_done;
        logic [LEVEL_W-1:0]       noise_level;
        logic [BYTE_W-1:0]        frame_peak;
        logic [FRAME_NUM_W-1:0]   frame_number;
        logic [LENGTH_W-1:0]      frame_count;
    } t_result;

endpackage

// File: src/decimating_peak_level_meter.sv
// A kept sample's word is registered and appears on the output in the cycle after it is accepted.
// Throughput: one input word per cycle; the output register frees in the same
// cycle that its word is taken, so the input stalls only when the output does.
// Skipped samples produce no output word.
// Reset: synchronous, active low; clears the phase, count, peak, frame index
// and output valid, and loads the default configuration.
// ----------------------------------------------------------------------------
// decimating_peak_level_meter
// Decimates a 16-bit audio stream, emits the high byte of each kept sample
// and reports peak level, class and frame index at the end of each frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimating_peak_level_meter
    import dplm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Configuration write port.
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,

    // Input stream.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [SAMPLE_W-1:0]    i_s_axis_tdata,   // [15:0] audio_sample

    // Output stream.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [7:0] sample_byte, [9:8] noise_level, [17:10] frame_peak,
    // [49:18] frame_number, [61:50] frame_count, [63:62] zero
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic                   o_m_axis_tlast    // frame_done
);

    t_cfg    r_cfg;
    t_result stat_result;
    t_result r_out;
    logic    r_out_valid;
    logic    in_accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decimation_factor <= RST_FACTOR;
            r_cfg.frame_length      <= RST_LENGTH;
            r_cfg.low_thr           <= RST_LOW_THR;
            r_cfg.high_thr          <= RST_HIGH_THR;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DECIMATION: begin
                    r_cfg.decimation_factor <= i_cfg_wdata[FACTOR_W-1:0];
                end
                CFG_FRAME_LENGTH: begin
                    r_cfg.frame_length <= i_cfg_wdata[LENGTH_W-1:0];
                end
                CFG_LOW_THR: begin
                    r_cfg.low_thr <= i_cfg_wdata[THRESH_W-1:0];
                end
                CFG_HIGH_THR: begin
                    r_cfg.high_thr <= i_cfg_wdata[THRESH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The input is taken whenever the output register is empty or being drained.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    dplm_frame_stat u_frame_stat (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (in_accept),
        .i_audio_sample (i_s_axis_tdata),
        .o_result       (stat_result)
    );

    // Output register: valid flag under reset, payload without.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= stat_result.keep;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && stat_result.keep) begin
            r_out <= stat_result;
        end
    end

    // Pack the output word.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out.frame_done;
    assign o_m_axis_tdata  = {2'b00, r_out.frame_count, r_out.frame_number,
                              r_out.frame_peak, r_out.noise_level, r_out.sample_byte};

endmodule

// File: src/dplm_frame_stat.sv
// ----------------------------------------------------------------------------
// dplm_frame_stat
// Decimation phase, running peak, kept count and frame index. Produces the
// result for the current input sample and updates its state on acceptance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimating_peak_level_meter_macros.svh"

module dplm_frame_stat
    import dplm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_accept,
    input  logic [SAMPLE_W-1:0] i_audio_sample,
    output t_result             o_result
);

    logic [PHASE_W-1:0]     r_phase;
    logic [LENGTH_W-1:0]    r_kept_count;
    logic [BYTE_W-1:0]      r_peak;
    logic [FRAME_NUM_W-1:0] r_frame_counter;

    logic [PHASE_W-1:0]     n_phase;
    logic [LENGTH_W-1:0]    n_kept_count;
    logic [BYTE_W-1:0]      n_peak;
    logic [FRAME_NUM_W-1:0] n_frame_counter;

    logic [FACTOR_W-1:0]    eff_factor;
    logic [LENGTH_W-1:0]    eff_length;
    logic [FACTOR_W-1:0]    phase_inc;
    logic                   keep;
    logic [BYTE_W-1:0]      hi_byte;
    logic [BYTE_W-1:0]      magnitude;
    logic [BYTE_W-1:0]      peak_upd;
    logic [LENGTH_W-1:0]    count_inc;
    logic                   done;
    logic [LEVEL_W-1:0]     level;

    // Clamp the configured factor and length into their working ranges.
    always_comb begin
        if (i_cfg.decimation_factor == '0) begin
            eff_factor = MIN_FACTOR;
        end else if (i_cfg.decimation_factor > MAX_FACTOR) begin
            eff_factor = MAX_FACTOR;
        end else begin
            eff_factor = i_cfg.decimation_factor;
        end
        eff_length = (i_cfg.frame_length == '0) ? MIN_FRAME_LENGTH : i_cfg.frame_length;
    end

    // Keep decision, magnitude of the high byte and frame completion.
    always_comb begin
        phase_inc = {1'b0, r_phase} + 4'd1;
        keep      = (phase_inc >= eff_factor);
        hi_byte   = i_audio_sample[SAMPLE_W-1 -: BYTE_W];
        // Negating 0x80 in eight bits gives 0x80, which reads as 128.
        magnitude = hi_byte[BYTE_W-1] ? (~hi_byte + 8'd1) : hi_byte;
        peak_upd  = (magnitude > r_peak) ? magnitude : r_peak;
        count_inc = r_kept_count + 12'd1;
        done      = (count_inc >= eff_length);

        if (peak_upd >= i_cfg.high_thr) begin
            level = LEVEL_LOUD;
        end else if (peak_upd >= i_cfg.low_thr) begin
            level = LEVEL_MODERATE;
        end else begin
            level = LEVEL_QUIET;
        end
    end

    // Result word; the frame fields read zero unless the frame completes.
    always_comb begin
        o_result             = '0;
        o_result.keep        = keep;
        o_result.sample_byte = hi_byte;
        o_result.frame_done  = done;
        if (done) begin
            o_result.noise_level  = level;
            o_result.frame_peak   = peak_upd;
            o_result.frame_number = r_frame_counter;
            o_result.frame_count  = count_inc;
        end
    end

    // Next state for an accepted sample.
    always_comb begin
        n_phase         = r_phase;
        n_kept_count    = r_kept_count;
        n_peak          = r_peak;
        n_frame_counter = r_frame_counter;
        if (i_accept) begin
            if (!keep) begin
                n_phase = phase_inc[PHASE_W-1:0];
            end else begin
                n_phase = '0;
                if (done) begin
                    n_kept_count    = '0;
                    n_peak          = '0;
                    n_frame_counter = r_frame_counter + 32'd1;
                end else begin
                    n_kept_count = count_inc;
                    n_peak       = peak_upd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= '0;
            r_kept_count    <= '0;
            r_peak          <= '0;
            r_frame_counter <= '0;
        end else begin
            r_phase         <= n_phase;
            r_kept_count    <= n_kept_count;
            r_peak          <= n_peak;
            r_frame_counter <= n_frame_counter;
        end
    end

    // A completed frame clears the peak and the count.
    `DPLM_ASSERT_NEXT(a_frame_clears, i_clk, i_rst_n, i_accept && keep && done, (r_kept_count == '0) && (r_peak == '0), "frame completion did not clear peak and count")

    // The frame index advances by one on each completed frame.
    `DPLM_ASSERT_NEXT(a_frame_index_step, i_clk, i_rst_n, i_accept && keep && done, r_frame_counter == $past(r_frame_counter) + 32'd1, "frame index did not advance by one")

    // The frame index holds while no frame completes.
    `DPLM_ASSERT_NEXT(a_frame_index_hold, i_clk, i_rst_n, !(i_accept && keep && done), $stable(r_frame_counter), "frame index moved without a completed frame")

    // The running peak never exceeds the largest byte magnitude.
    `DPLM_ASSERT_SAME(a_peak_range, i_clk, i_rst_n, 1'b1, r_peak <= MAX_MAGNITUDE, "running peak out of range")

endmodule
